[rtl/core/scc_pkg.sv]
// Shared types and constants for the strongly connected components engine.
// No dependencies; every other file of the block imports this package.
package scc_pkg;

   localparam int VERT_W = 6;
   localparam int NV_W   = 7;

   localparam logic [NV_W-1:0] NV_RESET = 7'd64;

   // request kinds
   localparam logic REQ_ADD_EDGE = 1'b0;
   localparam logic REQ_RUN      = 1'b1;

   // register index (paddr[2])
   localparam logic CSR_IDX_NUM_VERTICES = 1'b0;

   typedef struct packed {
      logic add_edge;
      logic p1_init;
      logic root_skip;
      logic root_take;
      logic scan_start;
      logic advance;
      logic push;
      logic pop;
      logic restore;
      logic p2_init;
      logic fs_pop;
      logic p2_root;
      logic emit;
      logic comp_end;
      logic flush;
      logic transposed;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic nb_visited;
      logic root_end;
      logic root_visited;
      logic depth_one;
      logic fs_empty;
      logic fs_visited;
      logic emit_ok;
      logic out_slot;
   } status_type;

endpackage

[rtl/core/scc_req_if.sv]
// Request channel of the component engine: valid/ready plus edge fields.
// Depends on scc_pkg for the vertex width.
interface scc_req_if import scc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [VERT_W-1:0] src_vertex;
   logic [VERT_W-1:0] dst_vertex;

   modport source (output valid, req_type, src_vertex, dst_vertex, input ready);
   modport sink   (input valid, req_type, src_vertex, dst_vertex, output ready);
endinterface

[rtl/core/scc_rsp_if.sv]
// Result channel of the component engine: valid/ready plus one vertex result.
// Depends on scc_pkg for the vertex width.
interface scc_rsp_if import scc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VERT_W-1:0] vertex;
   logic [VERT_W-1:0] component_index;
   logic              component_end;
   logic              last;
   logic              edge_overflow;

   modport source (output valid, vertex, component_index, component_end, last,
                   edge_overflow, input ready);
   modport sink   (input valid, vertex, component_index, component_end, last,
                   edge_overflow, output ready);
endinterface

[rtl/core/scc_ctrl.sv]
// Sequencer for the two depth-first passes of the component engine.
// Depends on scc_pkg; drives scc_dp through cmd_type and reads status_type.
module scc_ctrl import scc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_P1_INIT   = 4'd1;
   localparam logic [3:0] S_P1_ROOT   = 4'd2;
   localparam logic [3:0] S_SCAN_GO   = 4'd3;
   localparam logic [3:0] S_SCAN_WAIT = 4'd4;
   localparam logic [3:0] S_STEP      = 4'd5;
   localparam logic [3:0] S_RESTORE   = 4'd6;
   localparam logic [3:0] S_P2_INIT   = 4'd7;
   localparam logic [3:0] S_P2_POP    = 4'd8;
   localparam logic [3:0] S_P2_ROOT   = 4'd9;
   localparam logic [3:0] S_FINISH    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       pass2_ff, pass2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      pass2_in       = pass2_ff;
      cmd            = '0;
      cmd.transposed = pass2_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == REQ_RUN) state_in = S_P1_INIT;
               else cmd.add_edge = 1'b1;
            end
         end
         S_P1_INIT: begin
            cmd.p1_init = 1'b1;
            pass2_in    = 1'b0;
            state_in    = S_P1_ROOT;
         end
         S_P1_ROOT: begin
            priority if (stat.root_end) state_in = S_P2_INIT;
            else if (stat.root_visited) cmd.root_skip = 1'b1;
            else begin
               cmd.root_take = 1'b1;
               state_in      = S_SCAN_GO;
            end
         end
         S_SCAN_GO: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (stat.scan_done) state_in = S_STEP;
         end
         S_STEP: begin
            priority if (!stat.found) begin
               // vertex finished: drop its frame
               cmd.pop = 1'b1;
               priority if (!stat.depth_one) state_in = S_RESTORE;
               else if (pass2_ff) begin
                  cmd.comp_end = 1'b1;
                  state_in     = S_P2_POP;
               end else state_in = S_P1_ROOT;
            end else if (stat.nb_visited) begin
               cmd.advance = 1'b1;
               state_in    = S_SCAN_GO;
            end else if (!pass2_ff || stat.emit_ok) begin
               cmd.push = 1'b1;
               cmd.emit = pass2_ff;
               state_in = S_SCAN_GO;
            end
         end
         S_RESTORE: begin
            cmd.restore = 1'b1;
            state_in    = S_SCAN_GO;
         end
         S_P2_INIT: begin
            cmd.p2_init = 1'b1;
            pass2_in    = 1'b1;
            state_in    = S_P2_POP;
         end
         S_P2_POP: begin
            if (stat.fs_empty) state_in = S_FINISH;
            else begin
               cmd.fs_pop = 1'b1;
               state_in   = S_P2_ROOT;
            end
         end
         S_P2_ROOT: begin
            priority if (stat.fs_visited) state_in = S_P2_POP;
            else if (stat.emit_ok) begin
               cmd.p2_root = 1'b1;
               cmd.emit    = 1'b1;
               state_in    = S_SCAN_GO;
            end
         end
         S_FINISH: begin
            if (stat.out_slot) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[rtl/core/scc_dp.sv]
// Datapath of the component engine: edge memory and scan unit, walk and
// finish stacks, visited marks, pending and output result registers.
// Depends on scc_pkg; commanded by scc_ctrl.
module scc_dp import scc_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        stat,
   input  logic [VERT_W-1:0] add_src,
   input  logic [VERT_W-1:0] add_dst,
   input  logic              csr_wr,
   input  logic [NV_W-1:0]   csr_wdata,
   output logic [NV_W-1:0]   nv_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [VERT_W-1:0] rsp_vertex,
   output logic [VERT_W-1:0] rsp_component_index,
   output logic              rsp_component_end,
   output logic              rsp_last,
   output logic              rsp_edge_overflow
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int DW = AW + 1;
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int KW = VERT_W + EW;
   localparam int UW = KW + 1;
   localparam logic [NV_W-1:0] NMAX = NV_W'(MAX_VERTICES);
   localparam logic [CW-1:0]   ECAP = CW'(MAX_EDGES);

   // vertex count register
   logic [NV_W-1:0] nv_ff;
   logic [NV_W-1:0] n_eff;

   always_ff @(posedge clock) begin
      if (reset) nv_ff <= NV_RESET;
      else if (csr_wr) nv_ff <= csr_wdata;
   end

   assign nv_value = nv_ff;

   always_comb begin
      priority if (nv_ff == '0) n_eff = NV_W'(1);
      else if (nv_ff > NMAX) n_eff = NMAX;
      else n_eff = nv_ff;
   end

   // edge store
   logic [2*VERT_W-1:0] edge_mem [MAX_EDGES];
   logic [2*VERT_W-1:0] ed_rd_ff;
   logic [CW-1:0]       ecnt_ff;
   logic                ovf_ff;
   logic                add_ok, add_full;
   logic                scan_busy_ff, rv_ff, issue;
   logic [CW-1:0]       si_ff;

   assign add_ok   = cmd.add_edge && ({1'b0, add_src} < n_eff) && ({1'b0, add_dst} < n_eff);
   assign add_full = (ecnt_ff == ECAP);
   assign issue    = scan_busy_ff && (si_ff != ecnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (add_ok) begin
         if (add_full) ovf_ff <= 1'b1;
         else ecnt_ff <= ecnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (add_ok && !add_full) edge_mem[ecnt_ff[EW-1:0]] <= {add_src, add_dst};
      if (issue) ed_rd_ff <= edge_mem[si_ff[EW-1:0]];
   end

   // scan unit: smallest key at or above the cursor among matching edges
   logic [EW-1:0]     ridx_ff;
   logic              found_ff;
   logic [KW-1:0]     best_ff;
   logic [VERT_W-1:0] nb_ff;
   logic [VERT_W-1:0] cur_v_ff;
   logic [UW-1:0]     cur_cur_ff;
   logic [VERT_W-1:0] e_src, e_dst, e_nb;
   logic [KW-1:0]     e_key;
   logic              e_hit;
   logic              scan_done;

   assign e_src = ed_rd_ff[2*VERT_W-1:VERT_W];
   assign e_dst = ed_rd_ff[VERT_W-1:0];
   assign e_key = cmd.transposed ? {e_src, ridx_ff} : {VERT_W'(0), ridx_ff};
   assign e_nb  = cmd.transposed ? e_src : e_dst;
   assign e_hit = rv_ff && ({1'b0, e_src} < n_eff) && ({1'b0, e_dst} < n_eff)
                  && (cmd.transposed ? (e_dst == cur_v_ff) : (e_src == cur_v_ff))
                  && ({1'b0, e_key} >= cur_cur_ff)
                  && (!found_ff || (e_key < best_ff));
   assign scan_done = scan_busy_ff && !issue && !rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         rv_ff        <= 1'b0;
      end else begin
         rv_ff <= issue;
         if (cmd.scan_start) scan_busy_ff <= 1'b1;
         else if (scan_done) scan_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= si_ff[EW-1:0];
      if (cmd.scan_start) begin
         si_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         if (issue) si_ff <= si_ff + CW'(1);
         if (e_hit) begin
            found_ff <= 1'b1;
            best_ff  <= e_key;
            nb_ff    <= e_nb;
         end
      end
   end

   // walk stack: top frame lives in cur_v/cur_cur, the rest in memory
   logic [VERT_W+UW-1:0] wk_mem [MAX_VERTICES];
   logic [VERT_W+UW-1:0] wk_rd_ff;
   logic [DW-1:0]        depth_ff;
   logic [UW-1:0]        next_cur;
   logic [AW-1:0]        wk_waddr, wk_raddr;

   // finish stack and run counters
   logic [VERT_W-1:0]       fs_mem [MAX_VERTICES];
   logic [VERT_W-1:0]       fs_rd_ff;
   logic [DW-1:0]           fs_top_ff;
   logic [MAX_VERTICES-1:0] vis_ff;
   logic [NV_W-1:0]         root_ff;
   logic [VERT_W-1:0]       comp_ff;

   assign next_cur = {1'b0, best_ff} + UW'(1);
   assign wk_waddr = AW'(depth_ff - DW'(1));
   assign wk_raddr = AW'(depth_ff - DW'(2));

   always_ff @(posedge clock) begin
      priority if (cmd.root_take) begin
         cur_v_ff   <= root_ff[VERT_W-1:0];
         cur_cur_ff <= '0;
      end else if (cmd.p2_root) begin
         cur_v_ff   <= fs_rd_ff;
         cur_cur_ff <= '0;
      end else if (cmd.push) begin
         cur_v_ff   <= nb_ff;
         cur_cur_ff <= '0;
      end else if (cmd.advance) begin
         cur_cur_ff <= next_cur;
      end else if (cmd.restore) begin
         {cur_v_ff, cur_cur_ff} <= wk_rd_ff;
      end
      if (cmd.push) wk_mem[wk_waddr] <= {cur_v_ff, next_cur};
      if (cmd.pop) wk_rd_ff <= wk_mem[wk_raddr];
      if (cmd.pop && !cmd.transposed) fs_mem[fs_top_ff[AW-1:0]] <= cur_v_ff;
      if (cmd.fs_pop) fs_rd_ff <= fs_mem[AW'(fs_top_ff - DW'(1))];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         fs_top_ff <= '0;
         vis_ff    <= '0;
         root_ff   <= '0;
         comp_ff   <= '0;
      end else begin
         priority if (cmd.root_take || cmd.p2_root) depth_ff <= DW'(1);
         else if (cmd.push) depth_ff <= depth_ff + DW'(1);
         else if (cmd.pop) depth_ff <= depth_ff - DW'(1);

         priority if (cmd.p1_init) fs_top_ff <= '0;
         else if (cmd.pop && !cmd.transposed) fs_top_ff <= fs_top_ff + DW'(1);
         else if (cmd.fs_pop) fs_top_ff <= fs_top_ff - DW'(1);

         priority if (cmd.p1_init || cmd.p2_init) vis_ff <= '0;
         else if (cmd.root_take) vis_ff[root_ff[AW-1:0]] <= 1'b1;
         else if (cmd.p2_root) vis_ff[fs_rd_ff[AW-1:0]] <= 1'b1;
         else if (cmd.push) vis_ff[nb_ff[AW-1:0]] <= 1'b1;

         if (cmd.p1_init) root_ff <= '0;
         else if (cmd.root_take || cmd.root_skip) root_ff <= root_ff + NV_W'(1);

         if (cmd.p2_init) comp_ff <= '0;
         else if (cmd.comp_end) comp_ff <= comp_ff + VERT_W'(1);
      end
   end

   // pending result waits until the next one shows whether it ends a component
   logic              pend_vld_ff, out_vld_ff, out_load, out_slot;
   logic [VERT_W-1:0] pend_v_ff, pend_comp_ff;
   logic              pend_end_ff;

   assign out_slot = !out_vld_ff || rsp_ready;
   assign out_load = (cmd.emit && pend_vld_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (cmd.emit) pend_vld_ff <= 1'b1;
         else if (cmd.flush) pend_vld_ff <= 1'b0;
         if (out_load) out_vld_ff <= 1'b1;
         else if (rsp_ready) out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_v_ff    <= cmd.p2_root ? fs_rd_ff : nb_ff;
         pend_comp_ff <= comp_ff;
         pend_end_ff  <= 1'b0;
      end else if (cmd.comp_end) begin
         pend_end_ff <= 1'b1;
      end
      if (out_load) begin
         rsp_vertex          <= pend_v_ff;
         rsp_component_index <= pend_comp_ff;
         rsp_component_end   <= pend_end_ff || cmd.flush;
         rsp_last            <= cmd.flush;
         rsp_edge_overflow   <= ovf_ff;
      end
   end

   assign rsp_valid = out_vld_ff;

   always_comb begin
      stat.scan_done    = scan_done;
      stat.found        = found_ff;
      stat.nb_visited   = vis_ff[nb_ff[AW-1:0]];
      stat.root_end     = (root_ff >= n_eff);
      stat.root_visited = vis_ff[root_ff[AW-1:0]];
      stat.depth_one    = (depth_ff == DW'(1));
      stat.fs_empty     = (fs_top_ff == '0);
      stat.fs_visited   = vis_ff[fs_rd_ff[AW-1:0]];
      stat.emit_ok      = !pend_vld_ff || out_slot;
      stat.out_slot     = out_slot;
   end

endmodule

[rtl/core/strongly_connected_components.sv]
// Add-edge request: taken back to back while idle. Run request: two passes;
// each neighbour query starts a scan, reads every stored edge, drains and
// decides, and a run makes about 2*(vertices + edges) queries plus a restore
// step per return. One request at a time during a run; results leave through
// an output register. Synchronous active-high reset clears edge count,
// overflow flag and vertex count (64); edge memory is left as it is.
module strongly_connected_components import scc_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic             clock,
   input  logic             reset,
   scc_req_if.sink          req_ch,
   scc_rsp_if.source        rsp_ch,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cmd_type         cmd;
   status_type      stat;
   logic            csr_wr;
   logic [NV_W-1:0] nv_value;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_IDX_NUM_VERTICES);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_NUM_VERTICES) ? 32'(nv_value) : '0;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scc_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .add_src             (req_ch.src_vertex),
      .add_dst             (req_ch.dst_vertex),
      .csr_wr              (csr_wr),
      .csr_wdata           (csr_pwdata[NV_W-1:0]),
      .nv_value            (nv_value),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_vertex          (rsp_ch.vertex),
      .rsp_component_index (rsp_ch.component_index),
      .rsp_component_end   (rsp_ch.component_end),
      .rsp_last            (rsp_ch.last),
      .rsp_edge_overflow   (rsp_ch.edge_overflow)
   );

endmodule

[rtl/core/scc_checker.sv]
// Port-level checks for the component engine, bound to the top level.
// Depends on scc_pkg for the request kind codes.
module scc_checker import scc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end,
   input logic rsp_last
);

   logic [1:0] runs_ff, runs_in;
   logic       run_acc, last_acc;

   assign run_acc  = req_valid && req_ready && (req_kind == REQ_RUN);
   assign last_acc = rsp_valid && rsp_ready && rsp_last;

   // count runs whose final result has not yet been taken
   always_comb begin
      runs_in = runs_ff;
      if (run_acc && !last_acc) runs_in = runs_ff + 2'd1;
      else if (!run_acc && last_acc) runs_in = runs_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) runs_ff <= 2'd0;
      else runs_ff <= runs_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_end)
      else $error("final result does not close its component");

   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      (runs_ff != 2'd0) && !(rsp_valid && rsp_last) |-> !req_ready)
      else $error("request taken during a run");

   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (runs_ff != 2'd0))
      else $error("result outside a run");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.req_type),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_end   (rsp_ch.component_end),
   .rsp_last  (rsp_ch.last)
);

[tb/strongly_connected_components_test.sv]
// Self-checking bench for the strongly_connected_components engine.
// Depends on scc_pkg, scc_req_if and scc_rsp_if; a scoreboard class predicts
// each run's component listing and checks the result stream against it.
module strongly_connected_components_test;
   import scc_pkg::*;

   localparam int MAX_V       = 64;
   localparam int MAX_E       = 256;
   localparam int IDLE_LIMIT  = 2000000;
   localparam int SETTLE      = 40;
   localparam int EDGE_BUDGET = 150;

   typedef struct {
      logic [VERT_W-1:0] vertex;
      logic [VERT_W-1:0] component_index;
      logic              component_end;
      logic              last;
      logic              edge_overflow;
   } vtx_result_type;

   class scc_scoreboard_type;
      int unsigned vertex_count = NV_RESET;
      int unsigned edge_count;
      bit          overflow;
      int unsigned edge_tail [MAX_E];
      int unsigned edge_head [MAX_E];
      vtx_result_type listing_q [$];
      int          errors;
      int          runs;
      int          checked;

      function int unsigned active_vertices();
         if (vertex_count < 1) return 1;
         if (vertex_count > MAX_V) return MAX_V;
         return vertex_count;
      endfunction

      // next neighbour with ordering key at or above cur; -1 when exhausted
      function int next_neighbour(int unsigned v, bit transposed, inout int unsigned cur,
                                  input int unsigned n);
         int unsigned best;
         int unsigned key;
         int          pick;
         best = 32'hffff_ffff;
         pick = -1;
         for (int unsigned i = 0; i < edge_count; i++) begin
            if (edge_tail[i] >= n || edge_head[i] >= n) continue;
            if (!transposed) begin
               if (edge_tail[i] != v) continue;
               key = i;
            end else begin
               if (edge_head[i] != v) continue;
               key = edge_tail[i] * MAX_E + i;
            end
            if (key >= cur && key < best) begin
               best = key;
               pick = transposed ? edge_tail[i] : edge_head[i];
            end
         end
         if (pick >= 0) cur = best + 1;
         return pick;
      endfunction

      function void push_vertex(int unsigned v, int unsigned comp);
         vtx_result_type r;
         r.vertex          = v[VERT_W-1:0];
         r.component_index = comp[VERT_W-1:0];
         r.component_end   = 1'b0;
         r.last            = 1'b0;
         r.edge_overflow   = overflow;
         listing_q = {listing_q, r};
      endfunction

      function void note_request(logic req_type, logic [VERT_W-1:0] src,
                                 logic [VERT_W-1:0] dst);
         int unsigned n;
         bit          seen [MAX_V];
         int unsigned finish [MAX_V];
         int unsigned wvert [MAX_V];
         int unsigned wcur [MAX_V];
         int unsigned fs_top;
         int unsigned top;
         int unsigned comp;
         int unsigned c;
         int unsigned v;
         int          nb;
         n = active_vertices();
         if (req_type == REQ_ADD_EDGE) begin
            if (32'(src) >= n || 32'(dst) >= n) return;
            if (edge_count >= MAX_E) begin
               overflow = 1'b1;
               return;
            end
            edge_tail[edge_count] = 32'(src);
            edge_head[edge_count] = 32'(dst);
            edge_count++;
            return;
         end
         runs++;
         fs_top = 0;
         comp   = 0;
         foreach (seen[i]) seen[i] = 1'b0;
         // first pass: finishing order over the original graph
         for (int unsigned r = 0; r < n; r++) begin
            if (seen[r]) continue;
            seen[r]  = 1'b1;
            wvert[0] = r;
            wcur[0]  = 0;
            top      = 1;
            while (top > 0) begin
               v  = wvert[top-1];
               nb = next_neighbour(v, 1'b0, wcur[top-1], n);
               if (nb < 0) begin
                  if (fs_top < MAX_V) finish[fs_top++] = v;
                  top--;
               end else if (!seen[nb] && top < MAX_V) begin
                  seen[nb]   = 1'b1;
                  wvert[top] = nb;
                  wcur[top]  = 0;
                  top++;
               end
            end
         end
         // second pass: transpose, in reverse finishing order, preorder listing
         foreach (seen[i]) seen[i] = 1'b0;
         while (fs_top > 0) begin
            c = finish[--fs_top];
            if (seen[c]) continue;
            seen[c]  = 1'b1;
            wvert[0] = c;
            wcur[0]  = 0;
            top      = 1;
            push_vertex(c, comp);
            while (top > 0) begin
               v  = wvert[top-1];
               nb = next_neighbour(v, 1'b1, wcur[top-1], n);
               if (nb < 0) begin
                  top--;
               end else if (!seen[nb] && top < MAX_V) begin
                  seen[nb]   = 1'b1;
                  wvert[top] = nb;
                  wcur[top]  = 0;
                  top++;
                  push_vertex(nb, comp);
               end
            end
            listing_q[$].component_end = 1'b1;
            comp++;
         end
         listing_q[$].last = 1'b1;
      endfunction

      function void check_result(vtx_result_type got);
         vtx_result_type exp;
         checked++;
         if (listing_q.size() == 0) begin
            $display("%0t: unexpected result vertex %0d component %0d", $time,
                     got.vertex, got.component_index);
            errors++;
            return;
         end
         exp = listing_q.pop_front();
         if (got.vertex != exp.vertex) begin
            $display("%0t: vertex expected %0d actual %0d", $time, exp.vertex, got.vertex);
            errors++;
         end
         if (got.component_index != exp.component_index) begin
            $display("%0t: component_index expected %0d actual %0d", $time,
                     exp.component_index, got.component_index);
            errors++;
         end
         if (got.component_end !== exp.component_end) begin
            $display("%0t: component_end expected %0b actual %0b", $time,
                     exp.component_end, got.component_end);
            errors++;
         end
         if (got.last !== exp.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
            errors++;
         end
         if (got.edge_overflow !== exp.edge_overflow) begin
            $display("%0t: edge_overflow expected %0b actual %0b", $time,
                     exp.edge_overflow, got.edge_overflow);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   scc_req_if req_ch ();
   scc_rsp_if rsp_ch ();

   scc_scoreboard_type sb;
   int                 idle_cycles;
   int                 stall_left;

   strongly_connected_components u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // result side: random back-pressure, with runs of no stalling
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vtx_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.req_type, req_ch.src_vertex, req_ch.dst_vertex);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.vertex          = rsp_ch.vertex;
            got.component_index = rsp_ch.component_index;
            got.component_end   = rsp_ch.component_end;
            got.last            = rsp_ch.last;
            got.edge_overflow   = rsp_ch.edge_overflow;
            sb.check_result(got);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_psel && csr_penable))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     sb.listing_q.size());
            $display("strongly_connected_components regression: fail");
            $finish;
         end
      end
   end

   task automatic send_request(logic req_type, logic [VERT_W-1:0] src,
                               logic [VERT_W-1:0] dst);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.req_type   = req_type;
      req_ch.src_vertex = src;
      req_ch.dst_vertex = dst;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic add_edge(int unsigned src, int unsigned dst);
      send_request(REQ_ADD_EDGE, src[VERT_W-1:0], dst[VERT_W-1:0]);
   endtask

   task automatic run_search();
      send_request(REQ_RUN, VERT_W'($urandom), VERT_W'($urandom));
   endtask

   // drain every outstanding result, then let any add-edge settle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.listing_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_vertex_count(int unsigned value);
      wait_idle();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {CSR_IDX_NUM_VERTICES, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      sb.vertex_count = value & 7'h7f;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin
      int unsigned n;
      sb               = new();
      idle_cycles      = 0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_ADD_EDGE;
      req_ch.src_vertex = '0;
      req_ch.dst_vertex = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset vertex count, extremes, self loop, cycles
      run_search();
      add_edge(0, 63);
      add_edge(63, 0);
      add_edge(5, 5);
      add_edge(1, 2);
      add_edge(2, 3);
      add_edge(3, 1);
      add_edge(2, 63);
      run_search();
      write_vertex_count(1);
      run_search();
      write_vertex_count(0);
      run_search();
      write_vertex_count(4);
      add_edge(10, 2);        // unused tail: ignored
      add_edge(2, 42);        // unused head: ignored
      add_edge(3, 0);
      add_edge(0, 2);
      run_search();
      write_vertex_count(127);
      run_search();
      write_vertex_count(64);
      add_edge(42, 21);
      add_edge(21, 42);
      run_search();

      // random: mostly well-formed edges among the vertices in use
      n = 64;
      for (int i = 0; i < 200; i++) begin
         if (i % 40 == 39) begin
            case ($urandom_range(0, 5))
               0:       n = 64;
               1:       n = $urandom_range(0, 1) ? 0 : 127;
               default: n = $urandom_range(2, 20);
            endcase
            write_vertex_count(n);
            if (n < 1) n = 1;
            if (n > 64) n = 64;
         end
         if ($urandom_range(0, 99) < 12) begin
            run_search();
         end else if ($urandom_range(0, 99) < 80 && sb.edge_count < EDGE_BUDGET) begin
            add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
         end else begin
            add_edge($urandom_range(0, 63), $urandom_range(0, 63));
         end
      end
      run_search();

      // fill the edge store past capacity, then one full-size run
      write_vertex_count(64);
      while (sb.edge_count < MAX_E || !sb.overflow)
         add_edge($urandom_range(0, 63), $urandom_range(0, 63));
      add_edge($urandom_range(0, 63), $urandom_range(0, 63));
      run_search();
      wait_idle();

      $display("covered %0d searches, %0d component results, %0d edges stored",
               sb.runs, sb.checked, sb.edge_count);
      $display("overflow flag %0b, %0d mismatches", sb.overflow, sb.errors);
      if (sb.errors == 0 && sb.listing_q.size() == 0)
         $display("strongly_connected_components regression: pass");
      else
         $display("strongly_connected_components regression: fail");
      $finish;
   end

endmodule
